/* rtl/lmts_pkg.sv */
`default_nettype none
package lmts_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned TICK_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  localparam logic [COUNT_W-1:0] OAM_CYCLES    = 10'd80;
  localparam logic [COUNT_W-1:0] XFER_CYCLES   = 10'd172;
  localparam logic [COUNT_W-1:0] HBLANK_CYCLES = 10'd204;
  localparam logic [COUNT_W-1:0] LINE_CYCLES   = 10'd456;
  localparam logic [LINE_W-1:0]  LAST_LINE     = 8'd153;

  localparam logic [CFG_IDX_W-1:0] CFG_STAT_IRQ_ENABLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE     = 2'd2;

  // stat_irq_enables bit positions
  localparam int unsigned STAT_HBLANK = 0;
  localparam int unsigned STAT_VBLANK = 1;
  localparam int unsigned STAT_OAM    = 2;
  localparam int unsigned STAT_LYC    = 3;

  // irq_enables bit positions
  localparam int unsigned IE_VBLANK = 0;
  localparam int unsigned IE_STATUS = 1;

  typedef struct packed {
    logic [MODE_W-1:0] lcd_mode;
    logic [LINE_W-1:0] line_number;
    logic              vblank_request;
    logic              status_request;
    logic              render_line;
    logic              frame_done;
  } result_t;

endpackage
`default_nettype wire

/* rtl/lmts_tick_if.sv */
`default_nettype none
interface lmts_tick_if;
  logic                             valid;
  logic                             ready;
  logic [lmts_pkg::TICK_W-1:0]      tick_cycles;

  modport source (output valid, output tick_cycles, input ready);
  modport sink (input valid, input tick_cycles, output ready);
endinterface
`default_nettype wire

/* rtl/lmts_result_if.sv */
`default_nettype none
interface lmts_result_if;
  logic                             valid;
  logic                             ready;
  logic [lmts_pkg::MODE_W-1:0]      lcd_mode;
  logic [lmts_pkg::LINE_W-1:0]      line_number;
  logic                             vblank_request;
  logic                             status_request;
  logic                             render_line;
  logic                             frame_done;

  modport source (
    output valid, output lcd_mode, output line_number, output vblank_request,
    output status_request, output render_line, output frame_done, input ready
  );
  modport sink (
    input valid, input lcd_mode, input line_number, input vblank_request,
    input status_request, input render_line, input frame_done, output ready
  );
endinterface
`default_nettype wire

/* rtl/lcd_mode_timing_sequencer_top.sv */
`default_nettype none
// result: each accepted tick's result is registered and held valid until it is taken
// throughput: one tick per cycle while ready (no result pending or the result taken);
// each mode step is a single add, compare and select into the state and result registers
// reset (rst, synchronous): mode vblank, line 0, cycle count 0, all enables and
// line compare 0, no result pending
module lcd_mode_timing_sequencer_top #(
  parameter int unsigned VISIBLE_LINES = 144
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  lmts_tick_if.sink                               tick,
  lmts_result_if.source                           result,
  input  wire logic                               cfg_we,
  input  wire logic [lmts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lmts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [lmts_pkg::LINE_W-1:0] VIS_LINE = lmts_pkg::LINE_W'(VISIBLE_LINES);

  logic [3:0]                         stat_irq_enables;
  logic [1:0]                         irq_enables;
  logic [lmts_pkg::LINE_W-1:0]        line_compare;

  logic [lmts_pkg::COUNT_W-1:0]       cycle_count;
  logic [lmts_pkg::COUNT_W-1:0]       cycle_count_next;
  logic [lmts_pkg::MODE_W-1:0]        mode_reg;
  logic [lmts_pkg::MODE_W-1:0]        mode_reg_next;
  logic [lmts_pkg::LINE_W-1:0]        line_reg;
  logic [lmts_pkg::LINE_W-1:0]        line_reg_next;

  logic                               out_valid;
  lmts_pkg::result_t                  out_data;
  lmts_pkg::result_t                  out_data_next;

  logic                               accept;
  logic [lmts_pkg::COUNT_W-1:0]       count_sum;
  logic [lmts_pkg::LINE_W-1:0]        line_adv;
  logic [lmts_pkg::LINE_W-1:0]        line_cmp;
  logic                               src_hblank;
  logic                               src_vblank;
  logic                               src_oam;
  logic                               lyc_hit;

  assign tick.ready = !out_valid || result.ready;
  assign accept = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_irq_enables <= '0;
      irq_enables <= '0;
      line_compare <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmts_pkg::CFG_STAT_IRQ_ENABLES: stat_irq_enables <= cfg_data[3:0];
        lmts_pkg::CFG_IRQ_ENABLES:      irq_enables <= cfg_data[1:0];
        lmts_pkg::CFG_LINE_COMPARE:     line_compare <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_sum = cycle_count + lmts_pkg::COUNT_W'(tick.tick_cycles);
    line_adv = line_reg + 8'd1;
    cycle_count_next = count_sum;
    mode_reg_next = mode_reg;
    line_reg_next = line_reg;
    line_cmp = line_reg;
    src_hblank = 1'b0;
    src_vblank = 1'b0;
    src_oam = 1'b0;
    out_data_next.render_line = 1'b0;
    out_data_next.frame_done = 1'b0;
    unique case (mode_reg)
      lmts_pkg::MODE_OAM: begin
        if (count_sum >= lmts_pkg::OAM_CYCLES) begin
          cycle_count_next = '0;
          mode_reg_next = lmts_pkg::MODE_XFER;
        end
      end
      lmts_pkg::MODE_XFER: begin
        if (count_sum >= lmts_pkg::XFER_CYCLES) begin
          cycle_count_next = '0;
          mode_reg_next = lmts_pkg::MODE_HBLANK;
          out_data_next.render_line = 1'b1;
          src_hblank = 1'b1;
        end
      end
      lmts_pkg::MODE_HBLANK: begin
        if (count_sum >= lmts_pkg::HBLANK_CYCLES) begin
          cycle_count_next = '0;
          line_cmp = line_adv;
          line_reg_next = line_adv;
          if (line_adv == VIS_LINE) begin
            mode_reg_next = lmts_pkg::MODE_VBLANK;
            src_vblank = 1'b1;
            out_data_next.frame_done = 1'b1;
          end else begin
            mode_reg_next = lmts_pkg::MODE_OAM;
            src_oam = 1'b1;
          end
        end
      end
      lmts_pkg::MODE_VBLANK: begin
        if (count_sum >= lmts_pkg::LINE_CYCLES) begin
          cycle_count_next = '0;
          // compare sees the advanced count, 154 on the wrap step
          line_cmp = line_adv;
          line_reg_next = line_adv;
          if (line_adv > lmts_pkg::LAST_LINE) begin
            mode_reg_next = lmts_pkg::MODE_OAM;
            line_reg_next = '0;
            src_oam = 1'b1;
          end
        end
      end
      default: ;
    endcase

    lyc_hit = (line_compare == line_cmp) && stat_irq_enables[lmts_pkg::STAT_LYC];
    out_data_next.vblank_request = src_vblank && stat_irq_enables[lmts_pkg::STAT_VBLANK]
                                   && irq_enables[lmts_pkg::IE_VBLANK];
    // a vblank source with the vblank enable off falls through to the status line
    out_data_next.status_request = irq_enables[lmts_pkg::IE_STATUS] && (
        (src_hblank && stat_irq_enables[lmts_pkg::STAT_HBLANK])
        || (src_oam && stat_irq_enables[lmts_pkg::STAT_OAM])
        || (src_vblank && stat_irq_enables[lmts_pkg::STAT_VBLANK]
            && !irq_enables[lmts_pkg::IE_VBLANK])
        || lyc_hit);
    out_data_next.lcd_mode = mode_reg_next;
    out_data_next.line_number = line_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count <= '0;
      mode_reg <= lmts_pkg::MODE_VBLANK;
      line_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cycle_count <= cycle_count_next;
        mode_reg <= mode_reg_next;
        line_reg <= line_reg_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  assign result.valid = out_valid;
  assign result.lcd_mode = out_data.lcd_mode;
  assign result.line_number = out_data.line_number;
  assign result.vblank_request = out_data.vblank_request;
  assign result.status_request = out_data.status_request;
  assign result.render_line = out_data.render_line;
  assign result.frame_done = out_data.frame_done;

  // the counter never passes the longest mode period
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cycle_count < lmts_pkg::LINE_CYCLES)
    else $error("cycle count out of range");

  a_render_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.render_line |-> out_data.lcd_mode == lmts_pkg::MODE_HBLANK)
    else $error("render pulse outside hblank entry");

  a_frame_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |->
      out_data.lcd_mode == lmts_pkg::MODE_VBLANK && out_data.line_number == VIS_LINE)
    else $error("frame done without vblank entry");

  a_vblank_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.vblank_request |-> out_data.frame_done)
    else $error("vblank request without frame done");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(mode_reg) && $stable(line_reg) && $stable(cycle_count))
    else $error("state moved without an item");

endmodule
`default_nettype wire
